// ----- design/can_bit_timing_search_macros.svh -----
// assertion macros for the can bit timing search block
// used by can_bit_timing_search.sv
`ifndef CAN_BIT_TIMING_SEARCH_MACROS_SVH
`define CAN_BIT_TIMING_SEARCH_MACROS_SVH
// property that must hold at every clock edge outside reset
`define CBTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked on the following clock edge
`define CBTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- design/cbts_pkg.sv -----
`timescale 1ns / 1ps
// constants, types and state codes for the can bit timing search
// no dependencies
package cbts_pkg;
  localparam int unsigned MaxPrescaler = 512;
  localparam logic [8:0] TqMin = 9'd8;
  localparam logic [8:0] TqMax = 9'd385;
  localparam logic [8:0] Seg1Max = 9'd256;
  localparam logic [7:0] Seg2Max = 8'd128;
  localparam logic [31:0] KernelClockReset = 32'd80000000;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_INVALID = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV_TQ,
    S_CHECK_TQ,
    S_SEG2_MUL,
    S_SEG2_DIV,
    S_SEG1,
    S_ACT_MUL,
    S_DIV_ACT,
    S_ERR_MUL,
    S_ERR_DIV,
    S_DIV_ERR,
    S_COMPARE,
    S_NEXT,
    S_DONE
  } state_t;
endpackage

// ----- design/can_bit_timing_search.sv -----
`timescale 1ns / 1ps
// can bit timing search: one item in, one result item out
// an invalid item goes straight to the result; else every prescaler from 1 to MAX_PRESCALER (512)
//   is tried, each taking one to four 64-step bit-serial divisions
// throughput: one item at a time, the next is taken the cycle after the result item leaves
// reset: rst synchronous, clears control state and loads kclk with 80 MHz
`include "can_bit_timing_search_macros.svh"
module can_bit_timing_search #(
  parameter int unsigned MAX_PRESCALER = cbts_pkg::MaxPrescaler
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [23:0] target_bitrate, [33:24] sample_point, [39:34] zero
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [11:2] prescaler, [20:12] phase_seg1, [28:21] phase_seg2, [31:29] zero
  output logic [31:0] m_axis_tdata
);
  localparam int PW = $clog2(MAX_PRESCALER + 1);
  localparam int PRW = PW + 24;
  localparam int PTW = PW + 9;

  cbts_pkg::state_t state, state_next;
  logic [31:0] kclk;
  logic [23:0] rate;
  logic [9:0]  sp;
  logic [PW-1:0] p;
  logic [8:0]  tq;
  logic [7:0]  s2;
  logic [8:0]  s1;
  logic        found;
  logic [63:0] best_err;
  logic [PW-1:0] best_p;
  logic [8:0]  best_s1;
  logic [7:0]  best_s2;
  logic [31:0] cur_val;

  // shared restoring divider, one quotient bit per cycle
  logic [63:0] dnum, dden, dquo;
  logic [64:0] drem;
  logic [6:0]  dcnt;
  logic        dbusy;
  logic        dstart;
  logic [63:0] dstart_num, dstart_den;
  logic [64:0] drem_sh;

  // shared product register
  logic [63:0] mul_q;

  assign drem_sh = {drem[63:0], dnum[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt <= '0;
    end else if (dstart) begin
      dbusy <= 1'b1;
      dcnt <= 7'd64;
      dnum <= dstart_num;
      dden <= dstart_den;
      drem <= '0;
      dquo <= '0;
    end else if (dbusy) begin
      dnum <= {dnum[62:0], 1'b0};
      if (drem_sh >= {1'b0, dden}) begin
        drem <= drem_sh - {1'b0, dden};
        dquo <= {dquo[62:0], 1'b1};
      end else begin
        drem <= drem_sh;
        dquo <= {dquo[62:0], 1'b0};
      end
      dcnt <= dcnt - 7'd1;
      if (dcnt == 7'd1) begin
        dbusy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kclk <= cbts_pkg::KernelClockReset;
    end else if (cfg_we) begin
      kclk <= cfg_wdata;
    end
  end

  // narrow products feeding the divider
  logic [PRW-1:0] pr;
  logic [PTW-1:0] ptq;
  logic [19:0] seg2_num;
  logic [31:0] diff;
  logic [51:0] err_num;
  assign pr = PRW'(p) * PRW'(rate);
  assign ptq = PTW'(p) * PTW'(tq);
  assign seg2_num = 20'(dquo[8:0]) * 20'(10'd1000 - sp) + 20'd500;
  assign diff = (cur_val > {8'd0, rate}) ? cur_val - {8'd0, rate} : {8'd0, rate} - cur_val;
  assign err_num = 52'(diff) * 52'd1000000;

  // next state and divider launch
  always_comb begin
    state_next = state;
    dstart = 1'b0;
    dstart_num = '0;
    dstart_den = 64'd1;
    case (state)
      cbts_pkg::S_IDLE: if (s_axis_tvalid) state_next = cbts_pkg::S_PREP;
      cbts_pkg::S_PREP: begin
        if (kclk == 32'd0 || rate == 24'd0 || sp == 10'd0 || sp >= 10'd1000)
          state_next = cbts_pkg::S_DONE;
        else
          state_next = cbts_pkg::S_SEG2_MUL;
      end
      cbts_pkg::S_SEG2_MUL: begin
        // launch the rounded quanta-per-bit division
        dstart = 1'b1;
        dstart_num = 64'(kclk) + 64'(pr >> 1);
        dstart_den = 64'(pr);
        state_next = cbts_pkg::S_DIV_TQ;
      end
      cbts_pkg::S_DIV_TQ: if (!dbusy) state_next = cbts_pkg::S_CHECK_TQ;
      cbts_pkg::S_CHECK_TQ: begin
        if (dquo < {55'd0, cbts_pkg::TqMin} || dquo > {55'd0, cbts_pkg::TqMax}) begin
          state_next = cbts_pkg::S_NEXT;
        end else begin
          dstart = 1'b1;
          dstart_num = 64'(seg2_num);
          dstart_den = 64'd1000;
          state_next = cbts_pkg::S_SEG2_DIV;
        end
      end
      cbts_pkg::S_SEG2_DIV: if (!dbusy) state_next = cbts_pkg::S_SEG1;
      cbts_pkg::S_SEG1: begin
        if ({1'b0, tq} <= 10'd1 + {2'd0, s2} || tq - 9'd1 - {1'b0, s2} > cbts_pkg::Seg1Max)
          state_next = cbts_pkg::S_NEXT;
        else
          state_next = cbts_pkg::S_ACT_MUL;
      end
      cbts_pkg::S_ACT_MUL: begin
        dstart = 1'b1;
        dstart_num = {32'd0, kclk} + {1'b0, mul_q[63:1]};
        dstart_den = mul_q;
        state_next = cbts_pkg::S_DIV_ACT;
      end
      cbts_pkg::S_DIV_ACT: if (!dbusy) state_next = cbts_pkg::S_ERR_MUL;
      cbts_pkg::S_ERR_MUL: state_next = cbts_pkg::S_ERR_DIV;
      cbts_pkg::S_ERR_DIV: begin
        dstart = 1'b1;
        dstart_num = mul_q;
        dstart_den = {40'd0, rate};
        state_next = cbts_pkg::S_DIV_ERR;
      end
      cbts_pkg::S_DIV_ERR: if (!dbusy) state_next = cbts_pkg::S_COMPARE;
      cbts_pkg::S_COMPARE: state_next = cbts_pkg::S_NEXT;
      cbts_pkg::S_NEXT: begin
        if (p == PW'(MAX_PRESCALER)) state_next = cbts_pkg::S_DONE;
        else state_next = cbts_pkg::S_SEG2_MUL;
      end
      cbts_pkg::S_DONE: if (m_axis_tready) state_next = cbts_pkg::S_IDLE;
      default: state_next = cbts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cbts_pkg::S_IDLE;
    else state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else begin
      case (state)
        cbts_pkg::S_IDLE: begin
          if (s_axis_tvalid) begin
            rate <= s_axis_tdata[23:0];
            sp <= s_axis_tdata[33:24];
            found <= 1'b0;
            p <= PW'(1);
          end
        end
        cbts_pkg::S_CHECK_TQ: tq <= dquo[8:0];
        // seg2 is clamped as its quotient leaves the divider, ready for the seg1 checks
        cbts_pkg::S_SEG2_DIV: begin
          if (!dbusy) begin
            if (dquo[63:8] != 56'd0 || dquo[7:0] > cbts_pkg::Seg2Max) s2 <= cbts_pkg::Seg2Max;
            else if (dquo[7:0] == 8'd0) s2 <= 8'd1;
            else s2 <= dquo[7:0];
          end
        end
        // actual bitrate stays below 2^30, so 32 bits hold it
        cbts_pkg::S_DIV_ACT: if (!dbusy) cur_val <= dquo[31:0];
        cbts_pkg::S_COMPARE: begin
          if (!found || dquo < best_err) begin
            found <= 1'b1;
            best_err <= dquo;
            best_p <= p;
            best_s1 <= s1;
            best_s2 <= s2;
          end
        end
        cbts_pkg::S_NEXT: p <= p + PW'(1);
        default: ;
      endcase
    end
  end

  // registered products and seg1
  always_ff @(posedge clk) begin
    if (state == cbts_pkg::S_SEG1) begin
      s1 <= tq - 9'd1 - {1'b0, s2};
      mul_q <= 64'(ptq);
    end else if (state == cbts_pkg::S_ERR_MUL) begin
      mul_q <= 64'(err_num);
    end
  end

  logic [1:0] st_out;
  always_comb begin
    if (kclk == 32'd0 || rate == 24'd0 || sp == 10'd0 || sp >= 10'd1000)
      st_out = cbts_pkg::ST_INVALID;
    else if (!found)
      st_out = cbts_pkg::ST_NONE;
    else
      st_out = cbts_pkg::ST_OK;
  end

  assign s_axis_tready = (state == cbts_pkg::S_IDLE);
  assign m_axis_tvalid = (state == cbts_pkg::S_DONE);
  assign m_axis_tdata = (st_out == cbts_pkg::ST_OK) ?
    {3'd0, best_s2, best_s1, 10'(best_p), st_out} : {30'd0, st_out};

  `CBTS_ASSERT(a_one_side, !(s_axis_tready && m_axis_tvalid), "busy overlap")
  `CBTS_ASSERT_NEXT(a_div_start, dstart, dbusy, "divider did not start")
  `CBTS_ASSERT(a_p_range, state == cbts_pkg::S_IDLE || p != '0, "prescaler zero")
endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for can_bit_timing_search: directed table, then random items per phase
// depends on cbts_pkg and the can_bit_timing_search rtl
module tb;
  localparam int unsigned CycleLimit = 60_000_000;

  // one result item as the block reports it
  typedef struct packed {
    cbts_pkg::status_t status;
    logic [9:0] prescaler;
    logic [8:0] seg1;
    logic [7:0] seg2;
  } timing_t;

  // directed row: stimulus plus an optional typed-in result
  typedef struct {
    logic [23:0] rate;
    logic [9:0]  sp;
    bit          typed;
    cbts_pkg::status_t status;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  timing_t     pending_timings[$];
  logic [31:0] kernel_hz;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned cycles;

  can_bit_timing_search dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // search every prescaler, keep the first one with the smallest bitrate error
  function automatic timing_t best_timing(logic [31:0] kclk, logic [23:0] rate,
                                          logic [9:0] sp);
    longint unsigned tq, s1, s2, actual, diff, err, best_err;
    bit found;
    timing_t res;
    res = '0;
    found = 1'b0;
    best_err = 0;
    if (kclk == 0 || rate == 0 || sp == 0 || sp >= 1000) begin
      res.status = cbts_pkg::ST_INVALID;
      return res;
    end
    for (longint unsigned p = 1; p <= cbts_pkg::MaxPrescaler; p++) begin
      tq = (64'(kclk) + (p * rate) / 2) / (p * rate);
      if (tq < cbts_pkg::TqMin || tq > cbts_pkg::TqMax) continue;
      // tail of the bit after the sample point, rounded and clamped
      s2 = (tq * (1000 - sp) + 500) / 1000;
      if (s2 < 1) s2 = 1;
      if (s2 > cbts_pkg::Seg2Max) s2 = cbts_pkg::Seg2Max;
      if (tq <= 1 + s2) continue;
      s1 = tq - 1 - s2;
      if (s1 < 1 || s1 > cbts_pkg::Seg1Max) continue;
      actual = (64'(kclk) + (p * tq) / 2) / (p * tq);
      diff = (actual > rate) ? actual - rate : rate - actual;
      err = (diff * 1000000) / rate;
      if (!found || err < best_err) begin
        found = 1'b1;
        best_err = err;
        res.prescaler = p[9:0];
        res.seg1 = s1[8:0];
        res.seg2 = s2[7:0];
      end
    end
    res.status = found ? cbts_pkg::ST_OK : cbts_pkg::ST_NONE;
    if (!found) res = '{status: cbts_pkg::ST_NONE, default: '0};
    return res;
  endfunction

  // offer one item; valid stays high across back-to-back items
  task automatic send_item(logic [23:0] rate, logic [9:0] sp, timing_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, sp, rate};
    do @(posedge clk); while (!s_axis_tready);
    pending_timings.push_back(want);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [23:0] rate;
    logic [9:0] sp;
    logic [23:0] usual_rates[11];
    usual_rates = '{10000, 20000, 50000, 100000, 125000, 250000, 500000, 800000,
                    1000000, 2000000, 5000000};
    pick = $urandom_range(99);
    if (pick < 40) rate = usual_rates[$urandom_range(10)];
    else if (pick < 80) rate = 24'($urandom_range(1000, 2000000));
    else if (pick < 95) rate = 24'($urandom);
    else rate = '0;
    pick = $urandom_range(99);
    if (pick < 85) sp = 10'($urandom_range(1, 999));
    else if (pick < 95) sp = 10'($urandom);
    else sp = '0;
    send_item(rate, sp, best_timing(kernel_hz, rate, sp));
  endtask

  // register writes only once every result is back
  task automatic write_kernel_clock(logic [31:0] value);
    @(posedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_timings.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    kernel_hz = value;
  endtask

  // result side: random back-pressure and field-by-field check
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        timing_t got, want;
        got = '0;
        got.status = cbts_pkg::status_t'(m_axis_tdata[1:0]);
        got.prescaler = m_axis_tdata[11:2];
        got.seg1 = m_axis_tdata[20:12];
        got.seg2 = m_axis_tdata[28:21];
        if (pending_timings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %h", m_axis_tdata);
        end else begin
          want = pending_timings.pop_front();
          if (got.status !== want.status || got.prescaler !== want.prescaler ||
              got.seg1 !== want.seg1 || got.seg2 !== want.seg2) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected st %0d psc %0d s1 %0d s2 %0d, %s %0d %0d %0d %0d",
                       want.status, want.prescaler, want.seg1, want.seg2, "got st psc s1 s2",
                       got.status, got.prescaler, got.seg1, got.seg2);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("** can_bit_timing_search: FAILED **");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    timing_t want;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    kernel_hz = cbts_pkg::KernelClockReset;
    send_idle_pct = 30;
    recv_idle_pct = 49;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table at the reset kernel clock; extremes and error codes typed in
    rows = '{
      '{24'd0,        10'd875,  1'b1, cbts_pkg::ST_INVALID},  // zero bitrate
      '{24'd500000,   10'd0,    1'b1, cbts_pkg::ST_INVALID},  // zero sample point
      '{24'd500000,   10'd1000, 1'b1, cbts_pkg::ST_INVALID},  // sample point at 100 percent
      '{24'd500000,   10'd1023, 1'b1, cbts_pkg::ST_INVALID},  // widest sample point
      '{24'hFFFFFF,   10'd875,  1'b1, cbts_pkg::ST_NONE},     // too few quanta
      '{24'd1,        10'd500,  1'b1, cbts_pkg::ST_NONE},     // too many quanta
      '{24'd500000,   10'd875,  1'b0, cbts_pkg::ST_OK},
      '{24'd1000000,  10'd800,  1'b0, cbts_pkg::ST_OK},
      '{24'd125000,   10'd500,  1'b0, cbts_pkg::ST_OK},
      '{24'd250000,   10'd1,    1'b0, cbts_pkg::ST_OK},       // seg2 clamps high
      '{24'd250000,   10'd999,  1'b0, cbts_pkg::ST_OK},       // seg2 clamps to one
      '{24'd5000000,  10'd750,  1'b0, cbts_pkg::ST_OK},       // few quanta
      '{24'd10000,    10'd875,  1'b0, cbts_pkg::ST_OK},       // slow bus, deep prescalers
      '{24'd333333,   10'd600,  1'b0, cbts_pkg::ST_OK}        // never divides evenly
    };
    foreach (rows[i]) begin
      want = best_timing(kernel_hz, rows[i].rate, rows[i].sp);
      if (rows[i].typed) want = '{status: rows[i].status, default: '0};
      send_item(rows[i].rate, rows[i].sp, want);
    end
    repeat (28) send_random_item();

    // zero kernel clock: everything is invalid
    write_kernel_clock('0);
    repeat (3) send_random_item();

    // widest kernel clock, idling swapped
    write_kernel_clock(32'hFFFF_FFFF);
    send_idle_pct = 49;
    recv_idle_pct = 30;
    repeat (28) send_random_item();

    // random kernel clock, no idling
    write_kernel_clock($urandom_range(8_000_000, 160_000_000));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (27) send_random_item();

    @(posedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_timings.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("** can_bit_timing_search: PASSED **");
    end else begin
      $display("** can_bit_timing_search: FAILED **");
    end
    $finish;
  end
endmodule
